FILE: hw/rtl/vtek_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtek_pkg
// Shared types, codes and key tables for the escape key decoder.
// ----------------------------------------------------------------------------
package vtek_pkg;

    localparam int PENDING_LIMIT = 8;
    localparam int PEND_W        = $clog2(PENDING_LIMIT + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // byte codes
    localparam logic [7:0] ESC_BYTE    = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_TILDE    = 8'h7e;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7e;

    localparam logic [7:0] SEL_UP    = 8'h41;
    localparam logic [7:0] SEL_DOWN  = 8'h42;
    localparam logic [7:0] SEL_RIGHT = 8'h43;
    localparam logic [7:0] SEL_LEFT  = 8'h44;
    localparam logic [7:0] SEL_HOME  = 8'h48;
    localparam logic [7:0] SEL_END   = 8'h46;

    // key codes
    localparam logic [15:0] KEY_NONE   = 16'h0000;
    localparam logic [15:0] KEY_UP     = 16'hff52;
    localparam logic [15:0] KEY_DOWN   = 16'hff54;
    localparam logic [15:0] KEY_RIGHT  = 16'hff53;
    localparam logic [15:0] KEY_LEFT   = 16'hff51;
    localparam logic [15:0] KEY_HOME   = 16'hff50;
    localparam logic [15:0] KEY_END    = 16'hff57;
    localparam logic [15:0] KEY_DELETE = 16'hffff;
    localparam logic [15:0] KEY_RETURN = 16'hff0d;

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_CHAR = 2'd2,
        EV_STOP = 2'd3
    } t_ev_kind;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_KEY  = 2'd1,
        CMD_CHAR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] code;
        logic [7:0]  chr;
        logic        flag;
    } t_cmd;

    function automatic logic [15:0] escape_key(input logic [7:0] sel);
        logic [15:0] code;
        unique case (sel)
            SEL_UP:    code = KEY_UP;
            SEL_DOWN:  code = KEY_DOWN;
            SEL_RIGHT: code = KEY_RIGHT;
            SEL_LEFT:  code = KEY_LEFT;
            SEL_HOME:  code = KEY_HOME;
            SEL_END:   code = KEY_END;
            default:   code = KEY_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: hw/rtl/vt_escape_key_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt_escape_key_decoder_unit
// Terminal byte decoder turning VT escape sequences and plain bytes into
// key and character events, with a stop latch for CR/LF.
// ----------------------------------------------------------------------------
// A request beat is taken whenever the two-entry command queue has room,
// so beats may arrive back to back. Results leave one beat per cycle while
// m_axis_tready is high, from a registered output: a plain byte with streams
// active gives three beats, an arrow, home, end or delete key gives two, a
// take-stop request gives one, and bytes that only feed or drop a sequence
// give none. Each command is written into the queue, and the event sequencer
// then registers its beats at the output and sets the sustained rate.
// ----------------------------------------------------------------------------
module vt_escape_key_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // streams_active
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // byte_in
    input  logic        s_axis_tuser,    // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // key_code[15:0], char_byte[23:16], stop_flag[24]
    output logic [1:0]  m_axis_tuser,    // event_kind
    output logic        m_axis_tlast
);

    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               push;
    vtek_pkg::t_cmd     push_cmd;
    vtek_pkg::t_cmd     head;
    vtek_pkg::t_ev_kind ev_kind;
    logic [15:0]        ev_code;
    logic [7:0]         ev_char;
    logic               ev_flag;

    assign s_axis_tready = !q_full;

    vtek_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (s_axis_tvalid && !q_full),
        .i_req_type  (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    vtek_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    vtek_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (ev_kind),
        .o_code  (ev_code),
        .o_char  (ev_char),
        .o_flag  (ev_flag),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, ev_flag, ev_char, ev_code};
    assign m_axis_tuser = ev_kind;

endmodule

FILE: hw/rtl/vtek_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtek_front
// Accepts request beats, tracks escape sequences and the stop latch, and
// pushes one event command per beat that produces output.
// ----------------------------------------------------------------------------
module vtek_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    input  logic          i_accept,
    input  logic          i_req_type,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output vtek_pkg::t_cmd o_cmd
);

    logic                        r_streams;
    logic [vtek_pkg::PEND_W-1:0] r_pend;
    logic [vtek_pkg::PEND_W-1:0] n_pend;
    logic [7:0]                  r_seq [3];
    logic [7:0]                  n_seq [3];
    logic                        r_latch;
    logic                        n_latch;

    logic [vtek_pkg::PEND_W-1:0] pend_inc;
    logic [7:0]                  s1;
    logic [7:0]                  s2;
    logic [15:0]                 esc_code;
    logic                        is_crlf;
    logic                        is_print;

    assign o_cfg_ready = 1'b1;

    assign pend_inc = r_pend + vtek_pkg::PEND_W'(1);
    assign s1       = (r_pend == vtek_pkg::PEND_W'(1)) ? i_byte : r_seq[1];
    assign s2       = (r_pend == vtek_pkg::PEND_W'(2)) ? i_byte : r_seq[2];
    assign esc_code = vtek_pkg::escape_key(s2);
    assign is_crlf  = (i_byte == vtek_pkg::CH_CR) || (i_byte == vtek_pkg::CH_LF);
    assign is_print = (i_byte >= vtek_pkg::CH_PRINT_LO) && (i_byte <= vtek_pkg::CH_PRINT_HI);

    always_comb begin
        n_pend = r_pend;
        n_seq  = r_seq;
        n_latch = r_latch;
        o_push = 1'b0;
        o_cmd  = '{kind: vtek_pkg::CMD_STOP, code: 16'h0, chr: 8'h0, flag: 1'b0};
        if (i_accept) begin
            if (i_req_type) begin
                o_push     = 1'b1;
                o_cmd.flag = r_latch;
                n_latch    = 1'b0;
            end else if (r_pend != '0) begin
                if (r_pend >= vtek_pkg::PEND_W'(vtek_pkg::PENDING_LIMIT)) begin
                    n_pend = '0;
                end else begin
                    if (r_pend < vtek_pkg::PEND_W'(3)) begin
                        n_seq[r_pend[1:0]] = i_byte;
                    end
                    n_pend = pend_inc;
                    if (pend_inc >= vtek_pkg::PEND_W'(3) && r_seq[0] == vtek_pkg::ESC_BYTE
                            && s1 == vtek_pkg::CH_LBRACKET) begin
                        if (esc_code != vtek_pkg::KEY_NONE) begin
                            o_push     = 1'b1;
                            o_cmd.kind = vtek_pkg::CMD_KEY;
                            o_cmd.code = esc_code;
                            n_pend     = '0;
                        end else if (s2 == vtek_pkg::CH_THREE) begin
                            if (pend_inc >= vtek_pkg::PEND_W'(4)) begin
                                if (i_byte == vtek_pkg::CH_TILDE) begin
                                    o_push     = 1'b1;
                                    o_cmd.kind = vtek_pkg::CMD_KEY;
                                    o_cmd.code = vtek_pkg::KEY_DELETE;
                                end
                                n_pend = '0;
                            end
                        end else if (pend_inc >=
                                vtek_pkg::PEND_W'(vtek_pkg::PENDING_LIMIT)) begin
                            n_pend = '0;
                        end
                    end else if (pend_inc >= vtek_pkg::PEND_W'(vtek_pkg::PENDING_LIMIT)) begin
                        n_pend = '0;
                    end
                end
            end else if (i_byte == vtek_pkg::ESC_BYTE) begin
                n_seq[0] = i_byte;
                n_pend   = vtek_pkg::PEND_W'(1);
            end else if (is_crlf || is_print) begin
                if (is_crlf) begin
                    n_latch = 1'b1;
                end
                if (r_streams) begin
                    o_push     = 1'b1;
                    o_cmd.kind = vtek_pkg::CMD_CHAR;
                    o_cmd.chr  = i_byte;
                    o_cmd.code = (i_byte == vtek_pkg::CH_CR) ? vtek_pkg::KEY_RETURN
                                                             : {8'h00, i_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streams <= 1'b0;
            r_pend    <= '0;
            r_latch   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_streams <= i_cfg_data;
            end
            r_pend  <= n_pend;
            r_latch <= n_latch;
        end
    end

    // sequence bytes are only read after being written in the same sequence
    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
    end

endmodule

FILE: hw/rtl/vtek_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtek_fifo
// Short command queue between the classifier and the event sequencer.
// ----------------------------------------------------------------------------
module vtek_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vtek_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output vtek_pkg::t_cmd o_head
);

    vtek_pkg::t_cmd                r_mem [vtek_pkg::Q_DEPTH];
    logic [vtek_pkg::Q_AW-1:0]     r_wr;
    logic [vtek_pkg::Q_AW-1:0]     n_wr;
    logic [vtek_pkg::Q_AW-1:0]     r_rd;
    logic [vtek_pkg::Q_AW-1:0]     n_rd;
    logic [vtek_pkg::Q_CNT_W-1:0]  r_cnt;
    logic [vtek_pkg::Q_CNT_W-1:0]  n_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == vtek_pkg::Q_CNT_W'(vtek_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == vtek_pkg::Q_AW'(vtek_pkg::Q_DEPTH - 1)) ? '0
                                                                  : r_wr + vtek_pkg::Q_AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == vtek_pkg::Q_AW'(vtek_pkg::Q_DEPTH - 1)) ? '0
                                                                  : r_rd + vtek_pkg::Q_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + vtek_pkg::Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - vtek_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/vtek_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtek_back
// Expands each queued command into its event beats, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module vtek_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  vtek_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output vtek_pkg::t_ev_kind o_kind,
    output logic [15:0]       o_code,
    output logic [7:0]        o_char,
    output logic              o_flag,
    output logic              o_last
);

    logic               r_valid;
    logic               n_valid;
    vtek_pkg::t_ev_kind r_kind;
    vtek_pkg::t_ev_kind b_kind;
    logic [15:0]        r_code;
    logic [15:0]        b_code;
    logic [7:0]         r_char;
    logic [7:0]         b_char;
    logic               r_flag;
    logic               b_flag;
    logic               r_last;
    logic               b_last;
    logic [1:0]         r_beat;
    logic [1:0]         n_beat;
    logic               load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !i_empty && b_last;

    // beat decode
    always_comb begin
        b_kind = vtek_pkg::EV_STOP;
        b_code = 16'h0;
        b_char = 8'h0;
        b_flag = 1'b0;
        b_last = 1'b1;
        unique case (i_head.kind)
            vtek_pkg::CMD_STOP: begin
                b_flag = i_head.flag;
            end
            vtek_pkg::CMD_KEY: begin
                b_kind = (r_beat == 2'd0) ? vtek_pkg::EV_DOWN : vtek_pkg::EV_UP;
                b_code = i_head.code;
                b_last = (r_beat != 2'd0);
            end
            vtek_pkg::CMD_CHAR: begin
                b_char = i_head.chr;
                b_last = (r_beat == 2'd2);
                unique case (r_beat)
                    2'd0: begin
                        b_kind = vtek_pkg::EV_CHAR;
                        b_code = {8'h00, i_head.chr};
                    end
                    2'd1: begin
                        b_kind = vtek_pkg::EV_DOWN;
                        b_code = i_head.code;
                    end
                    default: begin
                        b_kind = vtek_pkg::EV_UP;
                        b_code = i_head.code;
                    end
                endcase
            end
            default: begin
                b_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_beat = b_last ? 2'd0 : r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind <= b_kind;
            r_code <= b_code;
            r_char <= b_char;
            r_flag <= b_flag;
            r_last <= b_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_code  = r_code;
    assign o_char  = r_char;
    assign o_flag  = r_flag;
    assign o_last  = r_last;

    a_stop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == vtek_pkg::EV_STOP |-> r_last)
        else $error("stop reply not marked last");

    a_flag_only_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind != vtek_pkg::EV_STOP |-> !r_flag)
        else $error("stop flag set on a non-stop event");

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat != 2'd3)
        else $error("beat counter out of range");

    a_up_after_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !i_empty && b_kind == vtek_pkg::EV_UP |->
            r_valid && r_kind == vtek_pkg::EV_DOWN && r_code == b_code)
        else $error("key up without matching key down");

endmodule
